// File: rtl/point_set_covariance_3d_assert.svh
// Assertion macros shared by the covariance block
`ifndef POINT_SET_COVARIANCE_3D_ASSERT_SVH
`define POINT_SET_COVARIANCE_3D_ASSERT_SVH

`ifndef SYNTHESIS

// Check that a property holds at every clock edge out of reset
`define PSC_ASSERT(lbl, clk_i, rst_ni, prop) \
    lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
        else $error("psc assertion failed");

// Check that a condition is never true out of reset
`define PSC_ASSERT_NEVER(lbl, clk_i, rst_ni, cond) \
    lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
        else $error("psc forbidden condition seen");

`else

`define PSC_ASSERT(lbl, clk_i, rst_ni, prop)
`define PSC_ASSERT_NEVER(lbl, clk_i, rst_ni, cond)

`endif

`endif

// File: rtl/psc_pkg.sv
// Shared widths, codes, types and helpers of the point set covariance block
`timescale 1ns / 1ps
`default_nettype none

package psc_pkg;

    // Field and state widths
    localparam int CRD_W      = 16;
    localparam int SUM_W      = 32;
    localparam int PSUM_W     = 48;
    localparam int PSUM_LO_W  = 24;
    localparam int PSUM_HI_W  = PSUM_W - PSUM_LO_W;
    localparam int PTS_W      = 16;
    localparam int VAR_W      = 31;
    localparam int COV_W      = 32;
    localparam int TR_W       = 33;
    localparam int STAT_W     = 2;
    localparam int DEN_W      = 2 * PTS_W;
    localparam int MAG_W      = 64;
    localparam int NUM_W      = 66;
    localparam int N_AXIS     = 3;
    localparam int N_ENT      = 6;
    localparam int ENT_IDX_W  = 3;
    localparam int AXIS_IDX_W = 2;
    localparam int DIV_STEPS  = MAG_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    // Stream word widths
    localparam int S_DATA_W = N_AXIS * CRD_W;
    localparam int M_DATA_W = 3 * VAR_W + 3 * COV_W + TR_W + PTS_W + STAT_W;

    // Default counter width
    localparam int COUNT_BITS_DEF = 16;

    // Status codes
    localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_SHORT = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_OVF   = 2'd2;

    // Index of the last matrix entry
    localparam logic [ENT_IDX_W-1:0] ENT_LAST = ENT_IDX_W'(N_ENT - 1);

    // Controller to datapath commands
    typedef struct packed {
        logic                 take;
        logic                 drain;
        logic                 mul_lo;
        logic                 mul_hi;
        logic                 mul_ab;
        logic                 diff;
        logic                 div_step;
        logic                 fix;
        logic                 load_out;
        logic [ENT_IDX_W-1:0] entry;
    } psc_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic short_set;
        logic out_free;
    } psc_stat_t;

    // First axis of a matrix entry (order xx, yy, zz, xy, xz, yz)
    function automatic logic [AXIS_IDX_W-1:0] axis_a(input logic [ENT_IDX_W-1:0] k);
        logic [AXIS_IDX_W-1:0] a;
        unique case (k)
            3'd0:    a = 2'd0;
            3'd1:    a = 2'd1;
            3'd2:    a = 2'd2;
            3'd3:    a = 2'd0;
            3'd4:    a = 2'd0;
            3'd5:    a = 2'd1;
            default: a = 2'd0;
        endcase
        return a;
    endfunction

    // Second axis of a matrix entry
    function automatic logic [AXIS_IDX_W-1:0] axis_b(input logic [ENT_IDX_W-1:0] k);
        logic [AXIS_IDX_W-1:0] b;
        unique case (k)
            3'd0:    b = 2'd0;
            3'd1:    b = 2'd1;
            3'd2:    b = 2'd2;
            3'd3:    b = 2'd1;
            3'd4:    b = 2'd2;
            3'd5:    b = 2'd2;
            default: b = 2'd0;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

// File: rtl/psc_ctrl.sv
// Sequencer for accumulation, per-entry arithmetic and result hand-off
`timescale 1ns / 1ps
`default_nettype none

module psc_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    input  wire logic              s_tlast,
    input  wire psc_pkg::psc_stat_t stat,
    output psc_pkg::psc_cmd_t       cmd
);
    import psc_pkg::*;

    localparam logic [3:0] ST_ACC   = 4'd0;
    localparam logic [3:0] ST_DRAIN = 4'd1;
    localparam logic [3:0] ST_MLO   = 4'd2;
    localparam logic [3:0] ST_MHI   = 4'd3;
    localparam logic [3:0] ST_MAB   = 4'd4;
    localparam logic [3:0] ST_DIFF  = 4'd5;
    localparam logic [3:0] ST_DIV   = 4'd6;
    localparam logic [3:0] ST_FIX   = 4'd7;
    localparam logic [3:0] ST_OUT   = 4'd8;

    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

    logic [3:0]           state_reg, state_next;
    logic [ENT_IDX_W-1:0] entry_reg, entry_next;
    logic [DIV_CNT_W-1:0] bit_reg, bit_next;

    // Next state and counters
    always_comb
    begin
        state_next = state_reg;
        entry_next = entry_reg;
        bit_next   = bit_reg;
        unique case (state_reg)
            ST_ACC:
            begin
                if (s_tvalid && s_tlast)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                entry_next = '0;
                state_next = stat.short_set ? ST_OUT : ST_MLO;
            end
            ST_MLO:  state_next = ST_MHI;
            ST_MHI:  state_next = ST_MAB;
            ST_MAB:  state_next = ST_DIFF;
            ST_DIFF:
            begin
                bit_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                bit_next = bit_reg + 1'b1;
                if (bit_reg == DIV_LAST)
                begin
                    state_next = ST_FIX;
                end
            end
            ST_FIX:
            begin
                if (entry_reg == ENT_LAST)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    entry_next = entry_reg + 1'b1;
                    state_next = ST_MLO;
                end
            end
            ST_OUT:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_ACC;
                end
            end
            default: state_next = ST_ACC;
        endcase
    end

    // Decode commands from the state
    always_comb
    begin
        cmd          = '0;
        cmd.entry    = entry_reg;
        cmd.take     = (state_reg == ST_ACC);
        cmd.drain    = (state_reg == ST_DRAIN);
        cmd.mul_lo   = (state_reg == ST_MLO);
        cmd.mul_hi   = (state_reg == ST_MHI);
        cmd.mul_ab   = (state_reg == ST_MAB);
        cmd.diff     = (state_reg == ST_DIFF);
        cmd.div_step = (state_reg == ST_DIV);
        cmd.fix      = (state_reg == ST_FIX);
        cmd.load_out = (state_reg == ST_OUT) && stat.out_free;
    end

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_ACC;
            entry_reg <= '0;
            bit_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            entry_reg <= entry_next;
            bit_reg   <= bit_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/psc_dpath.sv
// Accumulators, shared multipliers, bit-serial divider and output register
`timescale 1ns / 1ps
`default_nettype none

module psc_dpath #(
    parameter int COUNT_BITS = psc_pkg::COUNT_BITS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire psc_pkg::psc_cmd_t              cmd,
    input  wire logic                           s_tvalid,
    input  wire logic [psc_pkg::S_DATA_W-1:0]   s_tdata,
    input  wire logic                           m_tready,
    output logic                                m_tvalid,
    output logic [psc_pkg::M_DATA_W-1:0]        m_tdata,
    output psc_pkg::psc_stat_t                  stat
);
    import psc_pkg::*;

    localparam int PLO_W = PTS_W + PSUM_LO_W;
    localparam int PHI_W = PTS_W + 1 + PSUM_HI_W;
    localparam int SAB_W = 2 * SUM_W;
    localparam int PRD_W = 2 * CRD_W;

    localparam logic signed [NUM_W-1:0] VAR_MAX = NUM_W'((64'sd1 <<< VAR_W) - 64'sd1);
    localparam logic signed [NUM_W-1:0] COV_MAX = NUM_W'((64'sd1 <<< (COV_W - 1)) - 64'sd1);
    localparam logic signed [NUM_W-1:0] COV_MIN = -NUM_W'(64'sd1 <<< (COV_W - 1));

    logic                       accept;
    logic                       full;
    logic [COUNT_BITS-1:0]      count_reg;
    logic                       ovf_reg;
    logic                       acc_en_reg;
    logic                       short_reg;
    logic signed [CRD_W-1:0]    crd_reg [N_AXIS];
    logic signed [SUM_W-1:0]    sum_reg [N_AXIS];
    logic signed [PSUM_W-1:0]   psum_reg [N_ENT];
    logic [PTS_W-1:0]           n16;
    logic [DEN_W-1:0]           den_reg;
    logic signed [SUM_W-1:0]    op_a_reg, op_b_reg;
    logic [PLO_W-1:0]           plo_reg;
    logic signed [PHI_W-1:0]    phi_reg;
    logic signed [SAB_W-1:0]    sab_reg;
    logic signed [NUM_W-1:0]    nsum_reg;
    logic signed [NUM_W-1:0]    num;
    logic                       neg_reg;
    logic [MAG_W-1:0]           mag_reg;
    logic [DEN_W-1:0]           rem_reg;
    logic [DEN_W:0]             rem_shift;
    logic signed [NUM_W-1:0]    quot;
    logic signed [NUM_W-1:0]    clamped;
    logic signed [COV_W-1:0]    ent_reg [N_ENT];
    logic [TR_W-1:0]            trace;
    logic [STAT_W-1:0]          status;
    logic                       m_tvalid_reg;
    logic [M_DATA_W-1:0]        m_tdata_reg;

    assign accept = s_tvalid && cmd.take;
    assign full   = &count_reg;
    assign n16    = PTS_W'(count_reg);

    assign stat.short_set = (count_reg < COUNT_BITS'(2));
    assign stat.out_free  = !m_tvalid_reg || m_tready;

    // Count points and note points dropped at a full counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            ovf_reg    <= 1'b0;
            acc_en_reg <= 1'b0;
        end
        else
        begin
            acc_en_reg <= accept && !full;
            if (cmd.load_out)
            begin
                count_reg <= '0;
                ovf_reg   <= 1'b0;
            end
            else if (accept)
            begin
                if (full)
                begin
                    ovf_reg <= 1'b1;
                end
                else
                begin
                    count_reg <= count_reg + 1'b1;
                end
            end
        end
    end

    // Capture the coordinates of an accepted point
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int i = 0; i < N_AXIS; i++)
            begin
                crd_reg[i] <= s_tdata[i*CRD_W +: CRD_W];
            end
        end
    end

    // Accumulate axis sums and product sums, one lane each
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < N_AXIS; i++)
            begin
                sum_reg[i] <= '0;
            end
            for (int j = 0; j < N_ENT; j++)
            begin
                psum_reg[j] <= '0;
            end
        end
        else if (cmd.load_out)
        begin
            for (int i = 0; i < N_AXIS; i++)
            begin
                sum_reg[i] <= '0;
            end
            for (int j = 0; j < N_ENT; j++)
            begin
                psum_reg[j] <= '0;
            end
        end
        else if (acc_en_reg)
        begin
            for (int i = 0; i < N_AXIS; i++)
            begin
                sum_reg[i] <= sum_reg[i] + SUM_W'(crd_reg[i]);
            end
            for (int j = 0; j < N_ENT; j++)
            begin
                psum_reg[j] <= psum_reg[j] + PSUM_W'(PRD_W'(
                    crd_reg[axis_a(ENT_IDX_W'(j))] * crd_reg[axis_b(ENT_IDX_W'(j))]));
            end
        end
    end

    // Remaining set arithmetic: divisor, numerator parts, divider, fix-up
    assign num       = nsum_reg - NUM_W'(sab_reg);
    assign rem_shift = {rem_reg, mag_reg[MAG_W-1]};
    assign quot      = neg_reg ? (-$signed({2'b00, mag_reg})
                                  - NUM_W'(rem_reg != '0))
                               : $signed({2'b00, mag_reg});

    always_comb
    begin
        clamped = quot;
        if (cmd.entry < ENT_IDX_W'(N_AXIS))
        begin
            if (quot < 0)
            begin
                clamped = '0;
            end
            else if (quot > VAR_MAX)
            begin
                clamped = VAR_MAX;
            end
        end
        else
        begin
            if (quot < COV_MIN)
            begin
                clamped = COV_MIN;
            end
            else if (quot > COV_MAX)
            begin
                clamped = COV_MAX;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.drain)
        begin
            den_reg   <= DEN_W'(n16 * (n16 - 1'b1));
            short_reg <= stat.short_set;
        end
        if (cmd.mul_lo)
        begin
            plo_reg  <= PLO_W'(n16 * psum_reg[cmd.entry][PSUM_LO_W-1:0]);
            op_a_reg <= sum_reg[axis_a(cmd.entry)];
        end
        if (cmd.mul_hi)
        begin
            phi_reg  <= PHI_W'($signed({1'b0, n16})
                               * $signed(psum_reg[cmd.entry][PSUM_W-1:PSUM_LO_W]));
            op_b_reg <= sum_reg[axis_b(cmd.entry)];
        end
        if (cmd.mul_ab)
        begin
            sab_reg  <= SAB_W'(op_a_reg * op_b_reg);
            nsum_reg <= ($signed(NUM_W'(phi_reg)) <<< PSUM_LO_W)
                        + $signed(NUM_W'(plo_reg));
        end
        if (cmd.diff)
        begin
            neg_reg <= num[NUM_W-1];
            mag_reg <= MAG_W'(num[NUM_W-1] ? -num : num);
            rem_reg <= '0;
        end
        if (cmd.div_step)
        begin
            if (rem_shift >= {1'b0, den_reg})
            begin
                rem_reg <= DEN_W'(rem_shift - {1'b0, den_reg});
                mag_reg <= {mag_reg[MAG_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_shift[DEN_W-1:0];
                mag_reg <= {mag_reg[MAG_W-2:0], 1'b0};
            end
        end
        if (cmd.fix)
        begin
            ent_reg[cmd.entry] <= COV_W'(clamped);
        end
    end

    // Build the result word
    always_comb
    begin
        if (short_reg)
        begin
            trace  = '0;
            status = STATUS_SHORT;
        end
        else
        begin
            trace  = TR_W'(ent_reg[0][VAR_W-1:0]) + TR_W'(ent_reg[1][VAR_W-1:0])
                     + TR_W'(ent_reg[2][VAR_W-1:0]);
            status = ovf_reg ? STATUS_OVF : STATUS_OK;
        end
    end

    // Hold the result until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            if (short_reg)
            begin
                m_tdata_reg <= {status, n16, trace, {(3 * VAR_W + 3 * COV_W){1'b0}}};
            end
            else
            begin
                m_tdata_reg <= {status, n16, trace,
                                ent_reg[5], ent_reg[4], ent_reg[3],
                                ent_reg[2][VAR_W-1:0], ent_reg[1][VAR_W-1:0],
                                ent_reg[0][VAR_W-1:0]};
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

// File: rtl/point_set_covariance_3d.sv
// Top level of the streaming 3D point set covariance block
//
// Channel  Dir  Word contents (lowest bit first)                       Marker
// s_*      in   coord_x[15:0], coord_y[15:0], coord_z[15:0]            tlast = final_point
// m_*      out  var_xx 31, var_yy 31, var_zz 31, cov_xy 32, cov_xz 32,  none
//               cov_yz 32, total_variance 33, points_used 16, status 2
//
// Points are taken one per cycle while the input is open; a point's coordinates are
// registered and its products then added to the sums. After the last point the input
// closes: n*(n-1) is latched, then per entry three multiplies, a subtract, a restoring
// divide and a fix-up run, then the result loads. A set of fewer than two points skips the
// arithmetic. A result still waiting stretches the load cycle, so a stalled result only
// holds back the next set's end. Reset clears the sums, count and output valid flag.
`timescale 1ns / 1ps
`default_nettype none

`include "point_set_covariance_3d_assert.svh"

module point_set_covariance_3d #(
    parameter int COUNT_BITS = psc_pkg::COUNT_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [psc_pkg::S_DATA_W-1:0]  s_tdata,  // coord_x, coord_y, coord_z
    input  wire logic                          s_tlast,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [psc_pkg::M_DATA_W-1:0]       m_tdata   // var_xx, var_yy, var_zz, cov_xy,
                                                         // cov_xz, cov_yz, total_variance,
                                                         // points_used, status
);
    import psc_pkg::*;

    psc_cmd_t  cmd;
    psc_stat_t stat;

    // Sequencer
    psc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Arithmetic and storage
    psc_dpath #(
        .COUNT_BITS (COUNT_BITS)
    ) u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .s_tvalid (s_tvalid),
        .s_tdata  (s_tdata),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .stat     (stat)
    );

    assign s_tready = cmd.take;

    // A new result only appears after the sequencer loaded it
    `PSC_ASSERT(a_load_before_valid, clk, rst_n, $rose(m_tvalid) |-> $past(cmd.load_out))
    // Never overwrite a result that is still waiting
    `PSC_ASSERT(a_no_overwrite, clk, rst_n, cmd.load_out |-> (!m_tvalid || m_tready))
    // Input is closed while the divider runs
    `PSC_ASSERT_NEVER(a_closed_in_div, clk, rst_n, cmd.div_step && s_tready)

endmodule

`default_nettype wire
